// ----- design/assert_macros.svh -----
// Assertion helpers used by ordered_list_engine to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising edge of clk while rst_n is high.
`define OLE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property at every rising edge of clk, reset included.
`define OLE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/ole_pkg.sv -----
package ole_pkg;

  // Default capacity of the list and the most entries one list command shows.
  localparam int OLE_CAPACITY = 16;
  localparam int LIST_LIMIT   = 16;

  // Command codes carried in the input item.
  localparam logic [2:0] ACT_FRONT = 3'd0;
  localparam logic [2:0] ACT_BACK  = 3'd1;
  localparam logic [2:0] ACT_AT    = 3'd2;
  localparam logic [2:0] ACT_DEL   = 3'd3;
  localparam logic [2:0] ACT_LIST  = 3'd4;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_INVALID  = 3'd2,
    ST_RANGE    = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_NOTFOUND = 3'd5
  } ole_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic list_step;
  } ole_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic no_result;
    logic list_go;
    logic list_done;
    logic out_free;
  } ole_sts_t;

endpackage

// ----- design/ordered_list_engine.sv -----
// Ordered list engine: keeps up to CAPACITY signed 32-bit values in order.
// Commands enter on the in_ stream; action travels in in_tuser and the value
// and 1-based position in in_tdata. Results leave on the out_ stream, one per
// command, or one per listed entry for a list command, with out_tlast on the
// final result of each command and the result status in out_tuser.
// Insert, delete and empty-list commands: the item is taken, and then, once
// the output register is free, the entry registers shift and the result is
// registered. In a list command the entry registers rotate by one slot per
// cycle while the output register is free, and the front slot is shown at
// each step. Commands 5 to 7 give no result.
// One command is worked on at a time; the next is taken once the last result
// of the current one sits in the output register.
// A stalled receiver holds the output register, and the list rotation waits.
// Reset empties the list and drops any result not yet taken; no clearing pass
// is needed and an item can be taken in the first cycle after reset.
module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::OLE_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value_in[31:0], position[38:32], zero fill
  input  logic [2:0]  in_tuser,   // action[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // item_value[31:0], item_position[36:32],
                                  // length[41:37], zero fill
  output logic [2:0]  out_tuser,  // status[2:0]
  output logic        out_tlast
);
  import ole_pkg::*;

  ole_cmd_t           cmd;
  ole_sts_t           sts;
  ole_status_t        status;
  logic signed [31:0] item_value;
  logic [4:0]         item_position;
  logic [4:0]         length;

  ole_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ole_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .action        (in_tuser),
    .value_in      (in_tdata[31:0]),
    .position      (in_tdata[38:32]),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .status        (status),
    .item_value    (item_value),
    .item_position (item_position),
    .last          (out_tlast),
    .length        (length)
  );

  assign out_tdata = {6'd0, length, item_position, item_value};
  assign out_tuser = status;

`include "assert_macros.svh"

  // Only one command pulse at a time.
  `OLE_ASSERT_ALWAYS(a_one_cmd, $onehot0({cmd.load, cmd.exec, cmd.list_step}), "two commands at once")
  // A taken item closes the input until its work is done.
  `OLE_ASSERT(a_one_item, (in_tvalid && in_tready) |=> !in_tready, "second item taken while busy")
  // A result is only written into a free output register.
  `OLE_ASSERT(a_out_free, (cmd.exec || cmd.list_step) |-> sts.out_free, "result overwrote a waiting one")
  // A listed entry other than the last always carries a nonzero position.
  `OLE_ASSERT(a_list_pos, (out_tvalid && !out_tlast) |-> (out_tdata[36:32] != 5'd0), "listed entry without position")

endmodule

// ----- design/ole_ctrl.sv -----
module ole_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ole_pkg::ole_sts_t sts,
  output ole_pkg::ole_cmd_t cmd
);
  import ole_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  // Next state and command pulses.
  always_comb begin
    state_nxt     = state_r;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    cmd.list_step = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.no_result) begin
          state_nxt = S_IDLE;
        end else if (sts.list_go) begin
          state_nxt = S_LIST;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts.out_free) begin
          cmd.list_step = 1'b1;
          if (sts.list_done) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/ole_dp.sv -----
module ole_dp #(
  parameter int CAPACITY = ole_pkg::OLE_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          action,
  input  logic signed [31:0]  value_in,
  input  logic [6:0]          position,
  input  ole_pkg::ole_cmd_t   cmd,
  output ole_pkg::ole_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output ole_pkg::ole_status_t status,
  output logic signed [31:0]  item_value,
  output logic [4:0]          item_position,
  output logic                last,
  output logic [4:0]          length
);
  import ole_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = 8;

  // Stored command and list state.
  logic [2:0]         act_r;
  logic signed [31:0] val_r;
  logic [6:0]         pos_r;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [31:0]        ent_r   [CAPACITY];
  logic [31:0]        ent_nxt [CAPACITY];

  // Output register.
  logic               out_valid_r, out_valid_nxt;
  ole_status_t        st_r, st_nxt;
  logic signed [31:0] oval_r, oval_nxt;
  logic [4:0]         opos_r, opos_nxt;
  logic               olast_r, olast_nxt;
  logic [4:0]         olen_r, olen_nxt;
  logic               emit;

  logic [XW-1:0]       cnt_x, idx_x, ins_idx, pos_x, list_n;
  logic                full;
  ole_status_t         ins_st;
  logic [CAPACITY-1:0] match, lower, ge;

  assign cnt_x = XW'(cnt_r);
  assign idx_x = XW'(idx_r);
  assign pos_x = XW'(pos_r);
  assign full  = (cnt_x >= XW'(CAPACITY));
  assign list_n = (cnt_x < XW'(LIST_LIMIT)) ? cnt_x : XW'(LIST_LIMIT);

  // Insert slot and insert status.
  always_comb begin
    case (act_r)
      ACT_FRONT: ins_idx = '0;
      ACT_BACK:  ins_idx = cnt_x;
      default:   ins_idx = pos_x - XW'(1);
    endcase
    if (act_r == ACT_AT && pos_r == '0) begin
      ins_st = ST_INVALID;
    end else if (act_r == ACT_AT && pos_x > cnt_x + XW'(1)) begin
      ins_st = ST_RANGE;
    end else if (full) begin
      ins_st = ST_FULL;
    end else begin
      ins_st = ST_OK;
    end
  end

  // Delete search: mark the first matching slot and every slot behind it.
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      match[j] = (XW'(j) < cnt_x) && (ent_r[j] == val_r);
    end
    lower = match ^ (match - CAPACITY'(1));
    ge    = ~(lower >> 1);
  end

  assign sts.no_result = (act_r > ACT_LIST);
  assign sts.list_go   = (act_r == ACT_LIST) && (cnt_r != '0);
  assign sts.list_done = (idx_x + XW'(1) == cnt_x);
  assign sts.out_free  = !out_valid_r || out_ready;

  // Entry shifting, count update and result forming.
  always_comb begin
    ent_nxt   = ent_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    emit      = 1'b0;
    st_nxt    = ST_OK;
    oval_nxt  = '0;
    opos_nxt  = '0;
    olast_nxt = 1'b1;
    if (cmd.load) begin
      idx_nxt = '0;
    end
    if (cmd.exec) begin
      emit = 1'b1;
      case (act_r) inside
        ACT_FRONT, ACT_BACK, ACT_AT: begin
          st_nxt = ins_st;
          if (ins_st == ST_OK) begin
            for (int j = 1; j < CAPACITY; j++) begin
              if (XW'(j) > ins_idx) begin
                ent_nxt[j] = ent_r[j-1];
              end
            end
            for (int j = 0; j < CAPACITY; j++) begin
              if (XW'(j) == ins_idx) begin
                ent_nxt[j] = val_r;
              end
            end
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        ACT_DEL: begin
          if (cnt_r == '0) begin
            st_nxt = ST_EMPTY;
          end else if (match == '0) begin
            st_nxt = ST_NOTFOUND;
          end else begin
            for (int j = 0; j < CAPACITY - 1; j++) begin
              if (ge[j]) begin
                ent_nxt[j] = ent_r[j+1];
              end
            end
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        default: st_nxt = ST_EMPTY;
      endcase
    end
    if (cmd.list_step) begin
      // Rotate the stored entries by one so the front slot is the next one shown.
      for (int j = 0; j < CAPACITY - 1; j++) begin
        if (XW'(j) + XW'(1) < cnt_x) begin
          ent_nxt[j] = ent_r[j+1];
        end
      end
      for (int j = 0; j < CAPACITY; j++) begin
        if (XW'(j) + XW'(1) == cnt_x) begin
          ent_nxt[j] = ent_r[0];
        end
      end
      idx_nxt   = idx_r + CW'(1);
      emit      = (idx_x < XW'(LIST_LIMIT));
      oval_nxt  = ent_r[0];
      opos_nxt  = 5'(idx_x + XW'(1));
      olast_nxt = (idx_x + XW'(1) == list_n);
    end
    olen_nxt      = 5'(cnt_nxt);
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action;
      val_r <= value_in;
      pos_r <= position;
    end
    ent_r <= ent_nxt;
    if (emit) begin
      st_r    <= st_nxt;
      oval_r  <= oval_nxt;
      opos_r  <= opos_nxt;
      olast_r <= olast_nxt;
      olen_r  <= olen_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign status        = st_r;
  assign item_value    = oval_r;
  assign item_position = opos_r;
  assign last          = olast_r;
  assign length        = olen_r;

endmodule

// ----- tb/sv/ordered_list_engine_tb.sv -----
module ordered_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ole_pkg::*;

  localparam int LIST_CAPACITY = ole_pkg::OLE_CAPACITY;
  localparam int RANDOM_COMMANDS = 300;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REPORT_LIMIT = 60;

  // Action codes that the block ignores.
  localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [6:0]         position;
  } list_cmd_t;

  typedef struct packed {
    ole_status_t        status;
    logic signed [31:0] item_value;
    logic [4:0]         item_position;
    logic               last;
    logic [4:0]         length;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  ordered_list_engine #(
    .CAPACITY(LIST_CAPACITY)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #5 clk = ~clk;

  // Commands waiting to be driven, and the generator's view of the list.
  list_cmd_t          pending_items[$];
  logic signed [31:0] draft_list[$];
  int                 commands_planned = 0;

  // Scoreboard copy of the list and the results it implies.
  logic signed [31:0] list_model[$];
  list_result_t       expected_results[$];

  int  commands_accepted = 0;
  int  ignored_accepted = 0;
  int  results_checked = 0;
  int  error_count = 0;
  int  status_seen[6];
  int  cycle_count = 0;

  list_cmd_t cur_cmd;
  int        in_gap = 0;
  bit        in_idle_mode = 1'b1;
  int        out_stall = 0;
  bit        out_idle_mode = 1'b1;

  // Queue one result as the block should produce it after the command.
  function automatic void expect_result(ole_status_t st, logic signed [31:0] val,
                                        int pos, logic lst);
    list_result_t r;
    r.status        = st;
    r.item_value    = val;
    r.item_position = pos[4:0];
    r.last          = lst;
    r.length        = 5'(list_model.size());
    expected_results.push_back(r);
  endfunction

  // Apply one accepted command to the scoreboard list and queue its results.
  function automatic void predict_results(list_cmd_t cmd);
    ole_status_t st;
    int          n;
    int          hit;
    int          shown;
    st = ST_OK;
    n  = list_model.size();
    case (cmd.action) inside
      ACT_FRONT, ACT_BACK: begin
        if (n >= LIST_CAPACITY) st = ST_FULL;
        else if (cmd.action == ACT_FRONT) list_model.push_front(cmd.value);
        else list_model.push_back(cmd.value);
        expect_result(st, '0, 0, 1'b1);
      end
      ACT_AT: begin
        if (cmd.position == 0) st = ST_INVALID;
        else if (cmd.position > n + 1) st = ST_RANGE;
        else if (n >= LIST_CAPACITY) st = ST_FULL;
        else list_model.insert(cmd.position - 1, cmd.value);
        expect_result(st, '0, 0, 1'b1);
      end
      ACT_DEL: begin
        hit = -1;
        for (int i = 0; i < n; i++) begin
          if (hit < 0 && list_model[i] == cmd.value) hit = i;
        end
        if (n == 0) st = ST_EMPTY;
        else if (hit < 0) st = ST_NOTFOUND;
        else list_model.delete(hit);
        expect_result(st, '0, 0, 1'b1);
      end
      ACT_LIST: begin
        // Only the first LIST_LIMIT entries are shown on a wide list.
        shown = (n < LIST_LIMIT) ? n : LIST_LIMIT;
        if (shown == 0) expect_result(ST_EMPTY, '0, 0, 1'b1);
        for (int i = 0; i < shown; i++) begin
          expect_result(ST_OK, list_model[i], i + 1, i + 1 == shown);
        end
      end
      default: ;
    endcase
  endfunction

  // Values lean toward a few small ones so that duplicates and hits occur.
  function automatic logic [31:0] pick_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return $urandom_range(7);
    if (roll < 23) return 32'h7fffffff;
    if (roll < 26) return 32'h80000000;
    if (roll < 29) return 32'hffffffff;
    return $urandom;
  endfunction

  // Queue a command and track what it does to the list for later choices.
  task automatic add_cmd(input logic [2:0] action, input logic [31:0] value,
                         input logic [6:0] position);
    list_cmd_t c;
    int        n;
    int        hit;
    c.action   = action;
    c.value    = value;
    c.position = position;
    pending_items.push_back(c);
    n = draft_list.size();
    if (action <= ACT_LIST) commands_planned++;
    case (action)
      ACT_FRONT: if (n < LIST_CAPACITY) draft_list.push_front(value);
      ACT_BACK:  if (n < LIST_CAPACITY) draft_list.push_back(value);
      ACT_AT: begin
        if (position != 0 && position <= n + 1 && n < LIST_CAPACITY)
          draft_list.insert(position - 1, value);
      end
      ACT_DEL: begin
        hit = -1;
        for (int i = 0; i < n; i++) begin
          if (hit < 0 && draft_list[i] == value) hit = i;
        end
        if (hit >= 0) draft_list.delete(hit);
      end
      default: ;
    endcase
  endtask

  // Input side: present queued commands, with random gaps between items.
  always @(posedge clk) begin : drive_items
    logic present;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      present = in_tvalid;
      if (in_tvalid && in_tready) begin
        predict_results(cur_cmd);
        if (cur_cmd.action <= ACT_LIST) commands_accepted++;
        else ignored_accepted++;
        present = 1'b0;
        if ($urandom_range(29) == 0) in_idle_mode = ~in_idle_mode;
        in_gap = in_idle_mode ? $urandom_range(8) : 0;
      end
      if (!present) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (pending_items.size() != 0) begin
          cur_cmd = pending_items.pop_front();
          in_tuser <= cur_cmd.action;
          in_tdata <= {1'b0, cur_cmd.position, cur_cmd.value};
          present = 1'b1;
        end
      end
      in_tvalid <= present;
    end
  end

  // Output side: compare each result with the oldest expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    list_result_t got;
    logic         ready_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_checked++;
        got.status        = ole_status_t'(out_tuser);
        got.item_value    = out_tdata[31:0];
        got.item_position = out_tdata[36:32];
        got.length        = out_tdata[41:37];
        got.last          = out_tlast;
        if (out_tuser <= ST_NOTFOUND) status_seen[out_tuser]++;
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: unexpected result: expected none, got status %0d value %0d",
                     $time, got.status, got.item_value);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= REPORT_LIMIT) begin
              $display("%0t: result mismatch: expected status %0d value %0d pos %0d",
                       $time, want.status, want.item_value, want.item_position);
              $display("    last %0d length %0d; got status %0d value %0d pos %0d",
                       want.last, want.length, got.status, got.item_value,
                       got.item_position);
              $display("    last %0d length %0d", got.last, got.length);
            end
          end
        end
        if ($urandom_range(29) == 0) out_idle_mode = ~out_idle_mode;
        out_stall = out_idle_mode ? $urandom_range(8) : 0;
      end
      if (out_stall > 0) begin
        out_stall--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
      end
      out_tready <= ready_next;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("FAIL ordered_list_engine");
      $finish;
    end
  end

  initial begin
    int  n;
    int  roll;
    bit  grow;
    int  total_items;

    // Directed part: empty list, bad positions, extremes, duplicates, ignored actions.
    add_cmd(ACT_LIST, 32'h0, 7'd0);
    add_cmd(ACT_DEL, 32'd5, 7'd0);
    add_cmd(ACT_AT, 32'd9, 7'd0);
    add_cmd(ACT_AT, 32'd9, 7'd2);
    add_cmd(ACT_AT, 32'd9, 7'd127);
    add_cmd(ACT_AT, 32'd0, 7'd1);
    add_cmd(ACT_FRONT, 32'h7fffffff, 7'd0);
    add_cmd(ACT_BACK, 32'h80000000, 7'd127);
    add_cmd(ACT_AT, 32'hffffffff, 7'd4);
    add_cmd(ACT_AT, 32'd5, 7'd2);
    add_cmd(ACT_BACK, 32'd5, 7'd0);
    add_cmd(ACT_DEL, 32'd12345, 7'd0);
    add_cmd(ACT_DEL, 32'd5, 7'd0);
    add_cmd(ACT_LIST, 32'hffffffff, 7'd127);
    add_cmd(ACT_DEL, 32'h7fffffff, 7'd0);
    add_cmd(ACT_DEL, 32'hffffffff, 7'd0);
    add_cmd(ACT_UNUSED_FIRST, 32'hffffffff, 7'd127);
    add_cmd(ACT_UNUSED_FIRST + 3'd1, 32'd5, 7'd1);
    add_cmd(ACT_UNUSED_LAST, 32'h80000000, 7'd64);
    add_cmd(ACT_LIST, 32'd0, 7'd0);

    // Random part: alternate between filling the list up to capacity and
    // draining it, so that full and empty states recur many times.
    grow = 1'b1;
    while (commands_planned < RANDOM_COMMANDS + 20) begin
      n = draft_list.size();
      if (n == 0) grow = 1'b1;
      else if (n == LIST_CAPACITY && $urandom_range(3) == 0) grow = 1'b0;
      roll = $urandom_range(99);
      if (!grow) roll = (roll < 15) ? roll : roll + 45;
      if (roll < 60) begin
        case ($urandom_range(2))
          0: add_cmd(ACT_FRONT, pick_value(), 7'($urandom));
          1: add_cmd(ACT_BACK, pick_value(), 7'($urandom));
          default: add_cmd(ACT_AT, pick_value(), 7'($urandom_range(n + 1, 1)));
        endcase
      end else if (roll < 70 || (roll >= 105 && roll < 115)) begin
        if (n > 0) add_cmd(ACT_DEL, draft_list[$urandom_range(n - 1)], 7'($urandom));
        else add_cmd(ACT_DEL, pick_value(), 7'($urandom));
      end else if (roll < 80 || (roll >= 115 && roll < 125)) begin
        if (n > 0) add_cmd(ACT_DEL, draft_list[$urandom_range(n - 1)], 7'($urandom));
        else add_cmd(ACT_DEL, $urandom, 7'($urandom));
      end else if (roll < 85 || (roll >= 125 && roll < 130)) begin
        add_cmd(ACT_DEL, $urandom, 7'($urandom));
      end else if (roll < 92 || (roll >= 130 && roll < 137)) begin
        add_cmd(ACT_LIST, $urandom, 7'($urandom));
      end else if (roll < 94 || (roll >= 137 && roll < 139)) begin
        add_cmd(ACT_AT, pick_value(), 7'd0);
      end else if (roll < 97 || (roll >= 139 && roll < 142)) begin
        add_cmd(ACT_AT, pick_value(), 7'($urandom_range(127, n + 2)));
      end else if (!grow && roll < 105) begin
        add_cmd(ACT_DEL, draft_list[$urandom_range(n - 1)], 7'($urandom));
      end else begin
        add_cmd(3'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST)), $urandom,
                7'($urandom));
      end
    end
    total_items = pending_items.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every command to be taken and every result to come back.
    while (commands_accepted + ignored_accepted < total_items ||
           expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d list commands and %0d ignored actions; %0d results checked.",
             commands_accepted, ignored_accepted, results_checked);
    $display("Statuses ok/full/invalid/range/empty/not-found: %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5]);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("PASS ordered_list_engine");
    end else begin
      $display("FAIL ordered_list_engine");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/ole_pkg.sv
design/ole_ctrl.sv
design/ole_dp.sv
design/ordered_list_engine.sv
tb/sv/ordered_list_engine_tb.sv
